// ===== hdl/pma_pkg.sv =====
// Shared constants and control types for the pen position moving average.
package pma_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int COORD_W        = 24;
  localparam int PRES_W         = 16;
  localparam int WIN_W          = 7;
  localparam int ZOOM_W         = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int COORD_FRAC     = 8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STAB  = 2'd1;
  localparam logic [1:0] OP_PUSH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 1'd1;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 7'd2;
  localparam logic [ZOOM_W-1:0] ZOOM_RST   = 16'd256;

  typedef struct packed {
    logic capture;
    logic clear;
    logic add;
    logic read;
    logic replace;
    logic div_start;
    logic out_load;
  } pma_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic seed_last;
    logic div_busy;
    logic out_free;
  } pma_stat_t;

endpackage

// ===== hdl/pen_position_moving_average.sv =====
// Start: accept (history cleared), then N-1 seed writes. Push: accept, then add on an empty
// history, else read the oldest entry and replace it. Stabilize: accept, divider load, SW+8 =
// 38 divider steps (SW = 24 + log2(MAX_WINDOW)), result load; next beat taken the cycle after.
// Throughput: one beat at a time; the x/y serial dividers set the stabilize rate.
// A finished result waits in the output register while the next beat is taken.
// Reset: synchronous; history empty, sums zero, window 2, zoom 1.0; ring contents undefined.
module pen_position_moving_average import pma_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic [1:0]                opcode,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [PRES_W-1:0]         pos_pressure,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [COORD_W-1:0] avg_x,
  output logic signed [COORD_W-1:0] avg_y,
  output logic [PRES_W-1:0]         avg_pressure
);

  pma_cmd_t  cmd;
  pma_stat_t stat;

  pma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .opcode       (opcode),
    .stat         (stat),
    .cmd          (cmd)
  );

  pma_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_pressure (pos_pressure),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .avg_x        (avg_x),
    .avg_y        (avg_y),
    .avg_pressure (avg_pressure)
  );

endmodule

// ===== hdl/pma_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pma_div import pma_pkg::*; #(
  parameter int DW = 39,
  parameter int VW = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            take;

  assign trial    = {rem, q[DW-1]};
  assign diff     = trial - {1'b0, dsr};
  assign take     = trial >= {1'b0, dsr};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      q <= {q[DW-2:0], take};
      if (take) begin
        rem <= diff[VW-1:0];
      end else begin
        rem <= trial[VW-1:0];
      end
    end
  end

endmodule

// ===== hdl/pma_datapath.sv =====
// Datapath: config registers, history ring, running sums, dividers, result register.
module pma_datapath import pma_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic [PRES_W-1:0]          pos_pressure,
  input  pma_cmd_t                   cmd,
  output pma_stat_t                  stat,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [COORD_W-1:0]  avg_x,
  output logic signed [COORD_W-1:0]  avg_y,
  output logic [PRES_W-1:0]          avg_pressure
);

  localparam int PW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (NW > WIN_W) ? NW : WIN_W;
  localparam int SW   = COORD_W + PW;
  localparam int PSW  = PRES_W + PW;
  localparam int QXW  = SW + COORD_FRAC;
  localparam int DENW = NW + ZOOM_W;
  localparam int EW   = 2 * COORD_W + PRES_W;

  localparam logic [QXW-1:0] LIM_POS = QXW'(8388607);
  localparam logic [QXW-1:0] LIM_NEG = QXW'(8388608);
  localparam logic [PSW-1:0] LIM_P   = PSW'(65535);

  logic [WIN_W-1:0]          window_length;
  logic [ZOOM_W-1:0]         zoom_factor;
  logic signed [COORD_W-1:0] smp_x;
  logic signed [COORD_W-1:0] smp_y;
  logic [PRES_W-1:0]         smp_p;
  logic [PW-1:0]             ptr;
  logic [PW-1:0]             fill;
  logic signed [SW-1:0]      sum_x;
  logic signed [SW-1:0]      sum_y;
  logic [PSW-1:0]            sum_p;
  logic [EW-1:0]             mem [MAX_WINDOW];
  logic [EW-1:0]             rd_data;
  logic                      neg_x;
  logic                      neg_y;

  logic [CW-1:0]             wl_ext;
  logic [CW-1:0]             n_cl;
  logic [NW-1:0]             n;
  logic [ZOOM_W-1:0]         zoom_eff;
  logic [DENW-1:0]           den;
  logic [PW:0]               addr_sum;
  logic [PW:0]               addr_wrap;
  logic [PW-1:0]             wr_addr;
  logic [PW-1:0]             ptr_inc;
  logic [EW-1:0]             wr_data;
  logic signed [SW-1:0]      tx;
  logic signed [SW-1:0]      ty;
  logic [PSW-1:0]            tp;
  logic [SW-1:0]             mag_x;
  logic [SW-1:0]             mag_y;
  logic [QXW-1:0]            dvd_x;
  logic [QXW-1:0]            dvd_y;
  logic [QXW-1:0]            q_x;
  logic [QXW-1:0]            q_y;
  logic [PSW-1:0]            q_p;
  logic                      busy_x;
  logic                      busy_y;
  logic                      busy_p;
  logic signed [COORD_W-1:0] old_x;
  logic signed [COORD_W-1:0] old_y;
  logic [PRES_W-1:0]         old_p;

  function automatic logic [COORD_W-1:0] sat_coord(input logic neg, input logic [QXW-1:0] q);
    logic [QXW-1:0] nq;
    logic [COORD_W-1:0] r;
    nq = QXW'(0) - q;
    if (!neg) begin
      r = (q > LIM_POS) ? COORD_W'(8388607) : q[COORD_W-1:0];
    end else begin
      r = (q > LIM_NEG) ? COORD_W'(8388608) : nq[COORD_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext < CW'(2)) begin
      n_cl = CW'(2);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      n_cl = CW'(MAX_WINDOW);
    end else begin
      n_cl = wl_ext;
    end
  end

  assign n        = NW'(n_cl);
  assign zoom_eff = (zoom_factor == '0) ? ZOOM_W'(1) : zoom_factor;
  assign den      = DENW'(n) * DENW'(zoom_eff);

  assign addr_sum  = {1'b0, ptr} + {1'b0, fill};
  assign addr_wrap = (addr_sum >= (PW + 1)'(MAX_WINDOW)) ?
                     addr_sum - (PW + 1)'(MAX_WINDOW) : addr_sum;
  assign wr_addr   = addr_wrap[PW-1:0];
  assign ptr_inc   = (ptr == PW'(MAX_WINDOW - 1)) ? '0 : ptr + 1'b1;
  assign wr_data   = {smp_x, smp_y, smp_p};

  assign old_x = rd_data[EW-1 -: COORD_W];
  assign old_y = rd_data[PRES_W +: COORD_W];
  assign old_p = rd_data[PRES_W-1:0];

  assign tx    = sum_x + SW'(smp_x);
  assign ty    = sum_y + SW'(smp_y);
  assign tp    = sum_p + PSW'(smp_p);
  assign mag_x = tx[SW-1] ? SW'(-tx) : SW'(tx);
  assign mag_y = ty[SW-1] ? SW'(-ty) : SW'(ty);
  assign dvd_x = {mag_x, COORD_FRAC'(0)};
  assign dvd_y = {mag_y, COORD_FRAC'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RST;
      zoom_factor   <= ZOOM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW: window_length <= cfg_data[WIN_W-1:0];
        REG_ZOOM:   zoom_factor   <= cfg_data[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_x <= pos_x;
      smp_y <= pos_y;
      smp_p <= pos_pressure;
    end
    if (cmd.div_start) begin
      neg_x <= tx[SW-1];
      neg_y <= ty[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      fill  <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_p <= '0;
    end else if (cmd.clear) begin
      ptr   <= '0;
      fill  <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_p <= '0;
    end else if (cmd.add) begin
      fill  <= fill + 1'b1;
      sum_x <= tx;
      sum_y <= ty;
      sum_p <= tp;
    end else if (cmd.replace) begin
      ptr   <= ptr_inc;
      sum_x <= tx - SW'(old_x);
      sum_y <= ty - SW'(old_y);
      sum_p <= tp - PSW'(old_p);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add || cmd.replace) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= mem[ptr];
    end
  end

  pma_div #(.DW(QXW), .VW(DENW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_x),
    .divisor  (den),
    .busy     (busy_x),
    .quotient (q_x)
  );

  pma_div #(.DW(QXW), .VW(DENW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_y),
    .divisor  (den),
    .busy     (busy_y),
    .quotient (q_y)
  );

  pma_div #(.DW(PSW), .VW(NW)) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tp),
    .divisor  (n),
    .busy     (busy_p),
    .quotient (q_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_x        <= sat_coord(neg_x, q_x);
      avg_y        <= sat_coord(neg_y, q_y);
      avg_pressure <= (q_p > LIM_P) ? PRES_W'(65535) : q_p[PRES_W-1:0];
    end
  end

  assign stat.fill_zero = (fill == '0);
  assign stat.seed_last = ((NW'(fill) + NW'(2)) == n);
  assign stat.div_busy  = busy_x || busy_y || busy_p;
  assign stat.out_free  = !result_valid || !result_stall;

`ifndef NO_ASSERTIONS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten while held");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !(busy_x || busy_y || busy_p))
    else $error("divider restarted while busy");

  a_add_grows_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.add && !cmd.clear) |=> fill == $past(fill) + 1'b1)
    else $error("fill count did not advance on add");

  a_replace_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.replace |=> (fill == $past(fill) && fill != '0))
    else $error("replace changed the fill count");
`endif

endmodule

// ===== hdl/pma_ctrl.sv =====
// Controller state machine sequencing seed, push and stabilize beats.
module pma_ctrl import pma_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  logic [1:0] opcode,
  input  pma_stat_t  stat,
  output pma_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEED  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_PREAD = 3'd3;
  localparam logic [2:0] S_PREPL = 3'd4;
  localparam logic [2:0] S_SLOAD = 3'd5;
  localparam logic [2:0] S_SREPL = 3'd6;
  localparam logic [2:0] S_SDIV  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.capture = 1'b1;
          case (opcode)
            OP_START: begin
              cmd.clear  = 1'b1;
              state_next = S_SEED;
            end
            OP_STAB: state_next = S_SLOAD;
            OP_PUSH: state_next = stat.fill_zero ? S_ADD : S_PREAD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SEED: begin
        cmd.add = 1'b1;
        if (stat.seed_last) begin
          state_next = S_IDLE;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_IDLE;
      end
      S_PREAD: begin
        cmd.read   = 1'b1;
        state_next = S_PREPL;
      end
      S_PREPL: begin
        cmd.replace = 1'b1;
        state_next  = S_IDLE;
      end
      S_SLOAD: begin
        cmd.div_start = 1'b1;
        if (stat.fill_zero) begin
          state_next = S_SDIV;
        end else begin
          cmd.read   = 1'b1;
          state_next = S_SREPL;
        end
      end
      S_SREPL: begin
        cmd.replace = 1'b1;
        state_next  = S_SDIV;
      end
      S_SDIV: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
